// ----- design/tsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, codes and default sizes of the task slot allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int GROUPS_LEVEL3_DEF   = 2;
    localparam int GROUPS_LEVEL2_DEF   = 2;
    localparam int GROUPS_LEVEL1_DEF   = 2;
    localparam int GROUPS_LEVEL0_DEF   = 2;
    localparam int SLOTS_PER_GROUP_DEF = 32;

    // Fixed widths of the item fields
    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int TASK_W   = 8;
    localparam int TICK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int GROUP_W  = 4;
    localparam int SLOT_W   = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [TICK_W-1:0] MONITOR_FOUND = 16'h8000;
    localparam int                MONITOR_GROUP_SHIFT = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_LOCATE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// ----- design/task_slot_allocator.sv -----
`timescale 1ns / 1ps
// A tick goes from IDLE straight to DONE; an add searches the groups of its level one
// by one for a free slot; a delete or locate scans the slots of the groups of its level
// (one task-id memory read per slot), and a delete stops at its first hit. One item at
// a time: the next item is taken once the result sits in the output register. Reset
// clears the tick counter, the occupancy and unstarted masks and the monitor word;
// slot data memories are not cleared.
// ----------------------------------------------------------------------------
// task_slot_allocator
// Bitmap slot allocator with per-level group ranges and a task-id memory.
// ----------------------------------------------------------------------------
module task_slot_allocator #(
    parameter int GROUPS_LEVEL3   = tsa_pkg::GROUPS_LEVEL3_DEF,
    parameter int GROUPS_LEVEL2   = tsa_pkg::GROUPS_LEVEL2_DEF,
    parameter int GROUPS_LEVEL1   = tsa_pkg::GROUPS_LEVEL1_DEF,
    parameter int GROUPS_LEVEL0   = tsa_pkg::GROUPS_LEVEL0_DEF,
    parameter int SLOTS_PER_GROUP = tsa_pkg::SLOTS_PER_GROUP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // level[1:0], task_id[9:2], period[25:10], start_offset[41:26], zero pad
    input  logic [tsa_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // kind[1:0]
    input  logic [tsa_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status[1:0], group_index[5:2], slot_index[10:6], zero pad
    output logic [tsa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int TOTAL_GROUPS = GROUPS_LEVEL3 + GROUPS_LEVEL2 + GROUPS_LEVEL1
                                + GROUPS_LEVEL0;
    localparam int GW     = $clog2(TOTAL_GROUPS);
    localparam int SW     = $clog2(SLOTS_PER_GROUP);
    localparam int ADDR_W = GW + SW;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [GW-1:0] FIRST3 = GW'(0);
    localparam logic [GW-1:0] FIRST2 = GW'(GROUPS_LEVEL3);
    localparam logic [GW-1:0] FIRST1 = GW'(GROUPS_LEVEL3 + GROUPS_LEVEL2);
    localparam logic [GW-1:0] FIRST0 = GW'(GROUPS_LEVEL3 + GROUPS_LEVEL2 + GROUPS_LEVEL1);
    localparam logic [GW-1:0] LAST3  = GW'(GROUPS_LEVEL3 - 1);
    localparam logic [GW-1:0] LAST2  = GW'(GROUPS_LEVEL3 + GROUPS_LEVEL2 - 1);
    localparam logic [GW-1:0] LAST1  = GW'(GROUPS_LEVEL3 + GROUPS_LEVEL2
                                           + GROUPS_LEVEL1 - 1);
    localparam logic [GW-1:0] LAST0  = GW'(TOTAL_GROUPS - 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_GROUP - 1);

    // Slot storage
    logic [tsa_pkg::TASK_W-1:0]   r_task_mem   [DEPTH];
    logic [2*tsa_pkg::TICK_W-1:0] r_timing_mem [DEPTH];
    logic [tsa_pkg::TASK_W-1:0]   r_rd_task;

    // Control and bitmap state
    tsa_pkg::t_state              r_state, n_state;
    logic [tsa_pkg::TICK_W-1:0]   r_tick;
    logic [tsa_pkg::TICK_W-1:0]   r_monitor;
    logic [SLOTS_PER_GROUP-1:0]   r_occ       [TOTAL_GROUPS];
    logic [SLOTS_PER_GROUP-1:0]   r_unstarted [TOTAL_GROUPS];

    // Current item
    tsa_pkg::t_kind               r_kind;
    logic [tsa_pkg::TASK_W-1:0]   r_id;
    logic [tsa_pkg::TICK_W-1:0]   r_period;
    logic [tsa_pkg::TICK_W-1:0]   r_offset;

    // Scan position and compare stage
    logic [GW-1:0]                r_grp;
    logic [SW-1:0]                r_slot;
    logic [GW-1:0]                r_last_grp;
    logic                         r_pend;
    logic [GW-1:0]                r_pend_grp;
    logic [SW-1:0]                r_pend_slot;

    // Result
    logic                         r_found;
    tsa_pkg::t_status             r_res_status;
    logic [GW-1:0]                r_res_grp;
    logic [SW-1:0]                r_res_slot;
    logic                         r_m_valid;
    logic [tsa_pkg::OUT_DATA_W-1:0] r_m_data;

    logic                         w_accept;
    logic                         w_load_out;
    logic                         w_hit;
    logic                         w_record;
    logic                         w_scan_last;
    logic [SLOTS_PER_GROUP-1:0]   w_free;
    logic                         w_free_any;
    logic [SW-1:0]                w_free_slot;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic [ADDR_W-1:0]            w_wr_addr;
    logic [GW-1:0]                w_loc_grp;
    logic [SW-1:0]                w_loc_slot;
    logic [GW-1:0]                w_first;
    logic [GW-1:0]                w_last;
    tsa_pkg::t_kind               w_kind;

    assign w_kind   = tsa_pkg::t_kind'(i_s_axis_tuser);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load_out = (r_state == tsa_pkg::S_DONE) && (!r_m_valid || i_m_axis_tready);

    always_comb begin
        unique case (i_s_axis_tdata[1:0])
            2'd3:    begin w_first = FIRST3; w_last = LAST3; end
            2'd2:    begin w_first = FIRST2; w_last = LAST2; end
            2'd1:    begin w_first = FIRST1; w_last = LAST1; end
            default: begin w_first = FIRST0; w_last = LAST0; end
        endcase
    end

    // Lowest free slot of the group under test
    always_comb begin
        w_free      = ~r_occ[r_grp];
        w_free_any  = |w_free;
        w_free_slot = '0;
        for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_free_slot = SW'(i);
            end
        end
    end

    assign w_rd_addr   = {r_grp, r_slot};
    assign w_wr_addr   = {r_grp, w_free_slot};
    assign w_scan_last = (r_grp == r_last_grp) && (r_slot == LAST_SLOT);

    assign w_hit = r_pend && r_occ[r_pend_grp][r_pend_slot] && (r_rd_task == r_id);
    // Locate keeps the lowest hit of the latest group that holds the task
    assign w_record   = w_hit && (!r_found || (r_pend_grp != r_res_grp));
    assign w_loc_grp  = w_record ? r_pend_grp  : r_res_grp;
    assign w_loc_slot = w_record ? r_pend_slot : r_res_slot;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsa_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_kind)
                        tsa_pkg::KIND_TICK: n_state = tsa_pkg::S_DONE;
                        tsa_pkg::KIND_ADD:  n_state = tsa_pkg::S_ADD;
                        default:            n_state = tsa_pkg::S_SCAN;
                    endcase
                end
            end
            tsa_pkg::S_ADD: begin
                if (w_free_any || (r_grp == r_last_grp)) begin
                    n_state = tsa_pkg::S_DONE;
                end
            end
            tsa_pkg::S_SCAN: begin
                priority if (w_hit && (r_kind == tsa_pkg::KIND_DELETE)) begin
                    n_state = tsa_pkg::S_DONE;
                end else if (w_scan_last) begin
                    n_state = tsa_pkg::S_DRAIN;
                end
            end
            tsa_pkg::S_DRAIN: n_state = tsa_pkg::S_DONE;
            tsa_pkg::S_DONE: begin
                if (w_load_out) begin
                    n_state = tsa_pkg::S_IDLE;
                end
            end
            default: n_state = tsa_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_axis_tready = (r_state == tsa_pkg::S_IDLE);
        o_m_axis_tvalid = r_m_valid;
        o_m_axis_tdata  = r_m_data;
    end

    // Slot memories: one write port; the task-id memory has one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == tsa_pkg::S_ADD && w_free_any) begin
            r_task_mem[w_wr_addr]   <= r_id;
            r_timing_mem[w_wr_addr] <= {r_tick + r_offset, r_period};
        end
        r_rd_task <= r_task_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tsa_pkg::S_IDLE;
            r_tick    <= '0;
            r_monitor <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
            for (int g = 0; g < TOTAL_GROUPS; g++) begin
                r_occ[g]       <= '0;
                r_unstarted[g] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                tsa_pkg::S_IDLE: begin
                    r_pend  <= 1'b0;
                    r_found <= 1'b0;
                    if (w_accept) begin
                        r_kind       <= w_kind;
                        r_id         <= i_s_axis_tdata[9:2];
                        r_period     <= i_s_axis_tdata[25:10];
                        r_offset     <= i_s_axis_tdata[41:26];
                        r_grp        <= w_first;
                        r_last_grp   <= w_last;
                        r_slot       <= '0;
                        r_res_status <= tsa_pkg::STAT_OK;
                        r_res_grp    <= '0;
                        r_res_slot   <= '0;
                        if (w_kind == tsa_pkg::KIND_TICK) begin
                            r_tick <= r_tick + 1'b1;
                        end
                    end
                end
                tsa_pkg::S_ADD: begin
                    priority if (w_free_any) begin
                        r_occ[r_grp][w_free_slot] <= 1'b1;
                        if (r_grp < FIRST0) begin
                            r_unstarted[r_grp][w_free_slot] <= 1'b1;
                        end
                        r_res_grp  <= r_grp;
                        r_res_slot <= w_free_slot;
                    end else if (r_grp == r_last_grp) begin
                        r_res_status <= tsa_pkg::STAT_FULL;
                    end else begin
                        r_grp <= r_grp + 1'b1;
                    end
                end
                tsa_pkg::S_SCAN, tsa_pkg::S_DRAIN: begin
                    // Issue the next read while the previous one is compared
                    r_pend      <= (r_state == tsa_pkg::S_SCAN);
                    r_pend_grp  <= r_grp;
                    r_pend_slot <= r_slot;
                    if (r_slot == LAST_SLOT) begin
                        r_slot <= '0;
                        r_grp  <= r_grp + 1'b1;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end

                    if (r_kind == tsa_pkg::KIND_DELETE) begin
                        priority if (w_hit) begin
                            r_occ[r_pend_grp][r_pend_slot] <= 1'b0;
                            r_res_grp  <= r_pend_grp;
                            r_res_slot <= r_pend_slot;
                        end else if (r_state == tsa_pkg::S_DRAIN) begin
                            r_res_status <= tsa_pkg::STAT_NOT_FOUND;
                        end
                    end else begin
                        if (w_record) begin
                            r_found    <= 1'b1;
                            r_res_grp  <= r_pend_grp;
                            r_res_slot <= r_pend_slot;
                        end
                        if (r_state == tsa_pkg::S_DRAIN) begin
                            if (r_found || w_hit) begin
                                r_monitor <= tsa_pkg::MONITOR_FOUND
                                    | (tsa_pkg::TICK_W'(w_loc_grp)
                                       << tsa_pkg::MONITOR_GROUP_SHIFT)
                                    | tsa_pkg::TICK_W'(w_loc_slot);
                            end else begin
                                r_monitor    <= '0;
                                r_res_status <= tsa_pkg::STAT_NOT_FOUND;
                            end
                        end
                    end
                end
                tsa_pkg::S_DONE: begin
                    r_pend <= 1'b0;
                    if (w_load_out) begin
                        if (r_res_status == tsa_pkg::STAT_OK) begin
                            r_m_data <= {5'd0, tsa_pkg::SLOT_W'(r_res_slot),
                                         tsa_pkg::GROUP_W'(r_res_grp), r_res_status};
                        end else begin
                            r_m_data <= {5'd0, tsa_pkg::SLOT_W'(0),
                                         tsa_pkg::GROUP_W'(0), r_res_status};
                        end
                    end
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

endmodule

// ----- design/tsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks of the task slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [tsa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // One item in flight: no new item right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == tsa_pkg::STAT_OK
                             || o_m_axis_tdata[1:0] == tsa_pkg::STAT_FULL
                             || o_m_axis_tdata[1:0] == tsa_pkg::STAT_NOT_FOUND))
        else $error("undefined status code");

    // Errors report group and slot as zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[1:0] != tsa_pkg::STAT_OK)
            |-> (o_m_axis_tdata[10:2] == 9'd0))
        else $error("error result carries a slot position");

endmodule

bind task_slot_allocator tsa_checker u_tsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
